// ===== sv/btlv_pkg.sv =====
// Package with the word types and status codes of the BER-TLV stream parser.
`default_nettype none

package btlv_pkg;

  localparam int TAG_W   = 24;
  localparam int VLEN_W  = 16;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK          = 2'd0;
  localparam status_t ST_TRUNCATED   = 2'd1;
  localparam status_t ST_UNSUPPORTED = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_list;
  } byte_word_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [7:0]        value_byte;
    logic [VLEN_W-1:0] value_index;
    logic              value_present;
    logic              last_of_element;
    status_t           status;
  } res_word_t;

endpackage

`default_nettype wire

// ===== sv/ber_tlv_stream_parser.sv =====
// Top level of the BER-TLV stream parser: bytes in, tagged value words out.
//
//   channel | direction | handshake                 | word
//   --------+-----------+---------------------------+---------------------------------
//   byte    | in        | byte_valid / byte_stall   | byte_data  (byte_word_t)
//   res     | out       | res_valid  / res_stall    | res_data   (res_word_t)
//
// Each byte is held in the input register, then its parse step may write a word into
// the result register. A new byte is taken every cycle; the only limit is the result
// register, which must be free or being taken.
// Reset (rst, synchronous, active high) clears both stages and puts the parser in the
// state that expects the first tag byte of a list.
// byte_stall rises only while a byte sits in the input register and the result
// register holds a word that res_stall keeps from leaving.
`default_nettype none

module ber_tlv_stream_parser
  import btlv_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_word_t byte_data,
  output logic       res_valid,
  input  logic       res_stall,
  output res_word_t  res_data
);

  // Width of the count of long-form length bytes still to come.
  localparam int LW = $clog2(MAX_LENGTH_BYTES + 1);

  typedef enum logic [2:0] {
    PH_TAG1,
    PH_TAG2,
    PH_TAG3,
    PH_LEN1,
    PH_LENX,
    PH_VALUE
  } phase_t;

  // Input register.
  logic       s1_valid;
  byte_word_t s1_word;

  // Parse state.
  phase_t            phase, phase_next;
  logic [TAG_W-1:0]  tag_accum, tag_accum_next;
  logic [LW-1:0]     len_left, len_left_next;
  logic [VLEN_W-1:0] value_length, value_length_next;
  logic [VLEN_W-1:0] value_count, value_count_next;
  logic              halted, halted_next;

  // Result of one parse step.
  logic      emit;
  res_word_t emit_word;

  logic out_free;
  logic s1_go;

  // The result register can take a new word when it is empty or its word leaves now.
  assign out_free   = !res_valid || !res_stall;
  assign s1_go      = s1_valid && out_free;
  assign byte_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
    if (!byte_stall) begin
      s1_word <= byte_data;
    end
  end

  // One parse step on the byte held in the input register.
  always_comb begin
    logic [7:0]        b;
    logic              eol;
    logic [6:0]        n;
    logic [VLEN_W-1:0] new_len;
    logic              go_idle;
    logic              check_eol;
    logic              unsup;
    logic              at_last;

    b         = s1_word.data_byte;
    eol       = s1_word.end_of_list;
    n         = b[6:0];
    new_len   = {value_length[VLEN_W-9:0], b};
    go_idle   = 1'b0;
    check_eol = 1'b0;
    unsup     = 1'b0;
    at_last   = ({1'b0, value_count} + (VLEN_W+1)'(1)) >= {1'b0, value_length};

    phase_next        = phase;
    tag_accum_next    = tag_accum;
    len_left_next     = len_left;
    value_length_next = value_length;
    value_count_next  = value_count;
    halted_next       = halted;

    emit                      = 1'b0;
    emit_word.tag             = '0;
    emit_word.value_byte      = '0;
    emit_word.value_index     = '0;
    emit_word.value_present   = 1'b0;
    emit_word.last_of_element = 1'b0;
    emit_word.status          = ST_OK;

    if (halted) begin
      // Skip everything up to the end of the list after an unsupported length.
      if (eol) begin
        halted_next = 1'b0;
        go_idle     = 1'b1;
      end
    end else begin
      unique case (phase)
        PH_TAG1: begin
          tag_accum_next = {{(TAG_W-8){1'b0}}, b};
          phase_next     = (b[4:0] == 5'h1F) ? PH_TAG2 : PH_LEN1;
          check_eol      = 1'b1;
        end
        PH_TAG2: begin
          tag_accum_next = {tag_accum[TAG_W-9:0], b};
          phase_next     = b[7] ? PH_TAG3 : PH_LEN1;
          check_eol      = 1'b1;
        end
        PH_TAG3: begin
          tag_accum_next = {tag_accum[TAG_W-9:0], b};
          phase_next     = PH_LEN1;
          check_eol      = 1'b1;
        end
        PH_LEN1: begin
          if (b[7]) begin
            if (n == 7'd0 || n > 7'(MAX_LENGTH_BYTES)) begin
              unsup = 1'b1;
            end else begin
              len_left_next     = n[LW-1:0];
              value_length_next = '0;
              phase_next        = PH_LENX;
              check_eol         = 1'b1;
            end
          end else begin
            value_length_next = {{(VLEN_W-8){1'b0}}, b};
            value_count_next  = '0;
            if (b == 8'd0) begin
              // A zero-length element gives one word with no value.
              emit                      = 1'b1;
              emit_word.last_of_element = 1'b1;
              go_idle                   = 1'b1;
            end else begin
              phase_next = PH_VALUE;
              check_eol  = 1'b1;
            end
          end
        end
        PH_LENX: begin
          if (value_length[VLEN_W-1:VLEN_W-8] != 8'd0) begin
            // The length would not fit in sixteen bits.
            unsup = 1'b1;
          end else begin
            value_length_next = new_len;
            len_left_next     = len_left - LW'(1);
            check_eol         = 1'b1;
            if (len_left == LW'(1)) begin
              value_count_next = '0;
              if (new_len == '0) begin
                emit                      = 1'b1;
                emit_word.last_of_element = 1'b1;
                go_idle                   = 1'b1;
                check_eol                 = 1'b0;
              end else begin
                phase_next = PH_VALUE;
              end
            end
          end
        end
        PH_VALUE: begin
          emit                    = 1'b1;
          emit_word.value_byte    = b;
          emit_word.value_index   = value_count;
          emit_word.value_present = 1'b1;
          if (at_last) begin
            emit_word.last_of_element = 1'b1;
            go_idle                   = 1'b1;
          end else if (eol) begin
            emit_word.last_of_element = 1'b1;
            emit_word.status          = ST_TRUNCATED;
            go_idle                   = 1'b1;
          end else begin
            value_count_next = value_count + VLEN_W'(1);
          end
        end
        default: begin
          go_idle = 1'b1;
        end
      endcase
    end

    if (unsup) begin
      // Report once, then ignore the rest of the list unless it ends on this byte.
      emit                      = 1'b1;
      emit_word.last_of_element = 1'b1;
      emit_word.status          = ST_UNSUPPORTED;
      go_idle                   = 1'b1;
      halted_next               = !eol;
    end else if (check_eol && eol) begin
      // The list ended in the tag or length part of an element.
      emit                      = 1'b1;
      emit_word.last_of_element = 1'b1;
      emit_word.status          = ST_TRUNCATED;
      go_idle                   = 1'b1;
    end

    // The tag field always shows the tag as it stands after this byte.
    emit_word.tag = tag_accum_next;

    if (go_idle) begin
      phase_next        = PH_TAG1;
      len_left_next     = '0;
      value_length_next = '0;
      value_count_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TAG1;
      tag_accum    <= '0;
      len_left     <= '0;
      value_length <= '0;
      value_count  <= '0;
      halted       <= 1'b0;
    end else if (s1_go) begin
      phase        <= phase_next;
      tag_accum    <= tag_accum_next;
      len_left     <= len_left_next;
      value_length <= value_length_next;
      value_count  <= value_count_next;
      halted       <= halted_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_go && emit;
    end
    if (out_free) begin
      res_data <= emit_word;
    end
  end

endmodule

`default_nettype wire

// ===== sv/btlv_checker.sv =====
// Port-level checker for the BER-TLV stream parser and its bind to the top level.
`default_nettype none

module btlv_checker
  import btlv_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      res_valid,
  input logic      res_stall,
  input res_word_t res_data
);

  // A stalled result word stays put.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("result word changed while stalled");

  // Any error status closes its element.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status != ST_OK |-> res_data.last_of_element)
    else $error("error status without last_of_element");

  // A word without a value carries zero byte and index.
  a_no_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.value_present |->
      res_data.value_byte == 8'd0 && res_data.value_index == '0)
    else $error("empty word carries value data");

  // An unsupported length is reported in a word without a value.
  a_unsup: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status == ST_UNSUPPORTED |-> !res_data.value_present)
    else $error("unsupported length reported with a value");

endmodule

bind ber_tlv_stream_parser btlv_checker u_btlv_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

`default_nettype wire
